// File: sv/cflp_pkg.sv
// shared types and constants for the flash log pointer manager
`timescale 1ns / 1ps

package cflp_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int SECTOR_W = 7;
    localparam int SLOT_W   = 14;
    localparam int CNT_W    = 15;

    localparam logic [CNT_W-1:0] CAP_RESET = 15'd16256;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_MAIN_NEXT = 3'd1,
        OP_LOG_START = 3'd2,
        OP_LOG_NEXT  = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_LOG_OFF = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_DIFF,
        S_PUSH_MOVE,
        S_WRITE,
        S_MAIN_CHK,
        S_LOG_CHK,
        S_RS_DIST,
        S_RS_CMP,
        S_RS_MOVE,
        S_LC_DIST,
        S_LC_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            record_valid;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                erase_valid;
        logic [SECTOR_W-1:0] erase_sector;
        logic                write_valid;
        logic [SLOT_W-1:0]   write_slot;
        logic                read_valid;
        logic [SLOT_W-1:0]   read_slot;
        logic [CNT_W-1:0]    stored_count;
        logic [CNT_W-1:0]    log_count;
        logic                log_active;
        logic [SLOT_W-1:0]   next_main_slot;
        logic [SLOT_W-1:0]   next_log_slot;
    } t_result;

endpackage

// File: sv/cflp_alu.sv
// shared add / subtract unit with wrap at the ring size
`timescale 1ns / 1ps

module cflp_alu #(
    parameter int RING = 16384,
    parameter int UW   = 16
) (
    input  cflp_pkg::t_alu_op i_op,
    input  logic [UW-1:0]     i_a,
    input  logic [UW-1:0]     i_b,
    output logic [UW-1:0]     o_raw,
    output logic              o_neg,
    output logic [UW-1:0]     o_wrap
);
    import cflp_pkg::*;

    localparam logic [UW-1:0] RING_U = UW'(RING);

    always_comb begin
        if (i_op == ALU_SUB) begin
            o_raw  = i_a - i_b;
            o_neg  = o_raw[UW-1];
            o_wrap = o_neg ? o_raw + RING_U : o_raw;
        end else begin
            o_raw  = i_a + i_b;
            o_neg  = 1'b0;
            o_wrap = (o_raw >= RING_U) ? o_raw - RING_U : o_raw;
        end
    end

endmodule

// File: sv/circular_flash_log_pointer_manager_top.sv
// record ring pointer manager for an erase-sector flash log
// the result strobe follows the accepting edge once the single shared adder has stepped
//   through every pointer and count update in turn
// throughput: one word at a time; busy is high from accept until the strobe cycle, and a
//   new word may be accepted in the strobe cycle itself (the receiver cannot stall)
// reset: synchronous active low; pointers, counts and log reader cleared, cap to 16256
`timescale 1ns / 1ps

module circular_flash_log_pointer_manager_top #(
    parameter int SECTORS          = 128,
    parameter int SLOTS_PER_SECTOR = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cflp_pkg::t_cmd               i_cmd,
    input  logic                         i_cfg_we,
    input  logic [cflp_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_done,
    output cflp_pkg::t_result            o_result
);
    import cflp_pkg::*;

    // ring geometry; the write pointer may sit one past the last slot
    localparam int RING = SECTORS * SLOTS_PER_SECTOR;
    localparam int PW   = $clog2(RING + 1);
    localparam int SW   = $clog2(SECTORS + 1);
    localparam int OW   = (SLOTS_PER_SECTOR > 1) ? $clog2(SLOTS_PER_SECTOR) : 1;
    localparam int UW   = ((PW > CNT_W) ? PW : CNT_W) + 1;

    localparam logic [SW-1:0] SEC_FULL = SW'(SECTORS);
    localparam logic [OW-1:0] OFF_LAST = OW'(SLOTS_PER_SECTOR - 1);
    localparam logic [UW-1:0] SPS_U    = UW'(SLOTS_PER_SECTOR);

    // sequencer
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_tgt_log, n_tgt_log;     // which reader the resync / push steps work on

    // ring state
    logic [PW-1:0]    r_wp, n_wp;
    logic [SW-1:0]    r_wsec, n_wsec;
    logic [OW-1:0]    r_woff, n_woff;
    logic [PW-1:0]    r_mrd, n_mrd;
    logic [PW-1:0]    r_lrd, n_lrd;
    logic [CNT_W-1:0] r_mtot, n_mtot;
    logic [CNT_W-1:0] r_ltot, n_ltot;
    logic             r_log_on, n_log_on;
    logic [CNT_W-1:0] r_cap;

    // scratch and result fields
    logic [PW-1:0]    r_n, n_n;
    logic             r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic             r_ev, n_ev;
    logic [SW-1:0]    r_es, n_es;
    logic             r_wv, n_wv;
    logic [PW-1:0]    r_ws, n_ws;
    logic             r_rv, n_rv;
    logic [PW-1:0]    r_rs, n_rs;
    logic [CNT_W-1:0] r_lc, n_lc;

    logic    r_done;
    t_result r_result;

    // shared unit hookup
    t_alu_op       alu_op;
    logic [UW-1:0] alu_a, alu_b, alu_raw, alu_wrap;
    logic          alu_neg;

    logic             accept;
    logic             wp_wrap;
    logic [PW-1:0]    wp_eff;
    logic [SW-1:0]    wsec_eff;
    logic [OW-1:0]    woff_eff;
    logic [CNT_W-1:0] cap_eff;
    logic [PW-1:0]    sel_rd;
    logic [CNT_W-1:0] sel_tot;
    logic             push_hit;
    logic             push_next_log;

    cflp_alu #(
        .RING (RING),
        .UW   (UW)
    ) u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_raw  (alu_raw),
        .o_neg  (alu_neg),
        .o_wrap (alu_wrap)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    // append wraps a write pointer that ran off the end of the ring
    assign wp_wrap  = (r_wsec == SEC_FULL);
    assign wp_eff   = wp_wrap ? '0 : r_wp;
    assign wsec_eff = wp_wrap ? '0 : r_wsec;
    assign woff_eff = wp_wrap ? '0 : r_woff;

    // zero cap behaves as one
    assign cap_eff = (r_cap == '0) ? CNT_W'(1) : r_cap;

    assign sel_rd  = r_tgt_log ? r_lrd : r_mrd;
    assign sel_tot = r_tgt_log ? r_ltot : r_mtot;

    // reader inside the sector about to be erased, or full ring parked on the write slot
    assign push_hit = (!alu_neg && (alu_raw != '0) && (alu_raw < SPS_U))
                   || ((sel_tot == cap_eff) && (alu_raw == '0));

    // after the main reader, the log reader gets pushed too when it is active
    assign push_next_log = !r_tgt_log && r_log_on;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.operation)
                        OP_APPEND:    n_state = (woff_eff == '0) ? S_PUSH_DIFF : S_WRITE;
                        OP_MAIN_NEXT: n_state = S_RS_DIST;
                        OP_LOG_START: n_state = S_RS_DIST;
                        OP_LOG_NEXT:  n_state = r_log_on ? S_RS_DIST : S_LC_DIST;
                        default:      n_state = S_LC_DIST;
                    endcase
                end
            end
            S_PUSH_DIFF: begin
                if (push_hit) begin
                    n_state = S_PUSH_MOVE;
                end else if (push_next_log) begin
                    n_state = S_PUSH_DIFF;
                end else begin
                    n_state = S_RS_DIST;
                end
            end
            S_PUSH_MOVE: n_state = push_next_log ? S_PUSH_DIFF : S_RS_DIST;
            S_WRITE:     n_state = S_RS_DIST;
            S_RS_DIST:   n_state = S_RS_CMP;
            S_RS_CMP:    n_state = alu_neg ? S_RS_MOVE : r_ret;
            S_RS_MOVE:   n_state = r_ret;
            S_MAIN_CHK:  n_state = (r_mtot == '0) ? S_LC_DIST : S_RS_DIST;
            S_LOG_CHK:   n_state = ((r_ltot == '0) || !r_valid) ? S_LC_DIST : S_RS_DIST;
            S_LC_DIST:   n_state = r_log_on ? S_LC_CMP : S_DONE;
            S_LC_CMP:    n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath control and register next values
    always_comb begin
        n_ret     = r_ret;
        n_tgt_log = r_tgt_log;
        n_wp      = r_wp;
        n_wsec    = r_wsec;
        n_woff    = r_woff;
        n_mrd     = r_mrd;
        n_lrd     = r_lrd;
        n_mtot    = r_mtot;
        n_ltot    = r_ltot;
        n_log_on  = r_log_on;
        n_n       = r_n;
        n_valid   = r_valid;
        n_status  = r_status;
        n_ev      = r_ev;
        n_es      = r_es;
        n_wv      = r_wv;
        n_ws      = r_ws;
        n_rv      = r_rv;
        n_rs      = r_rs;
        n_lc      = r_lc;
        alu_op    = ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid  = i_cmd.record_valid;
                    n_status = ST_OK;
                    n_ev     = 1'b0;
                    n_es     = '0;
                    n_wv     = 1'b0;
                    n_ws     = '0;
                    n_rv     = 1'b0;
                    n_rs     = '0;
                    n_lc     = '0;
                    case (i_cmd.operation)
                        OP_APPEND: begin
                            n_wp      = wp_eff;
                            n_wsec    = wsec_eff;
                            n_woff    = woff_eff;
                            n_wv      = 1'b1;
                            n_ws      = wp_eff;
                            n_tgt_log = 1'b0;
                            if (woff_eff == '0) begin
                                n_ev = 1'b1;
                                n_es = wsec_eff;
                            end
                        end
                        OP_MAIN_NEXT: begin
                            n_tgt_log = 1'b0;
                            n_ret     = S_MAIN_CHK;
                        end
                        OP_LOG_START: begin
                            n_lrd     = r_mrd;
                            n_ltot    = r_mtot;
                            n_log_on  = 1'b1;
                            n_tgt_log = 1'b1;
                            n_ret     = S_LOG_CHK;
                        end
                        OP_LOG_NEXT: begin
                            n_tgt_log = 1'b1;
                            n_ret     = S_LOG_CHK;
                            if (!r_log_on) begin
                                n_status = ST_LOG_OFF;
                            end
                        end
                        OP_CLEAR: begin
                            n_wp   = '0;
                            n_wsec = '0;
                            n_woff = '0;
                            n_mrd  = '0;
                            n_mtot = '0;
                            if (r_log_on) begin
                                n_lrd  = '0;
                                n_ltot = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH_DIFF: begin
                // offset of the reader from the write slot
                alu_op = ALU_SUB;
                alu_a  = UW'(sel_rd);
                alu_b  = UW'(r_wp);
                if (!push_hit) begin
                    n_tgt_log = push_next_log;
                    n_ret     = S_WRITE;
                end
            end
            S_PUSH_MOVE: begin
                // reader jumps to the start of the next sector
                alu_op = ALU_ADD;
                alu_a  = UW'(r_wp);
                alu_b  = SPS_U;
                if (r_tgt_log) begin
                    n_lrd = alu_wrap[PW-1:0];
                end else begin
                    n_mrd = alu_wrap[PW-1:0];
                end
                n_tgt_log = push_next_log;
                n_ret     = S_WRITE;
            end
            S_WRITE: begin
                // plain increment, the pointer may land one past the end
                alu_op = ALU_ADD;
                alu_a  = UW'(r_wp);
                alu_b  = UW'(1);
                n_wp   = alu_raw[PW-1:0];
                if (r_woff == OFF_LAST) begin
                    n_woff = '0;
                    n_wsec = r_wsec + SW'(1);
                end else begin
                    n_woff = r_woff + OW'(1);
                end
                n_tgt_log = 1'b0;
                n_ret     = S_LC_DIST;
            end
            S_RS_DIST: begin
                alu_op = ALU_SUB;
                alu_a  = UW'(r_wp);
                alu_b  = UW'(sel_rd);
                n_n    = alu_wrap[PW-1:0];
            end
            S_RS_CMP: begin
                // negative means more pending than the cap allows
                alu_op = ALU_SUB;
                alu_a  = UW'(cap_eff);
                alu_b  = UW'(r_n);
                if (!alu_neg) begin
                    if (r_tgt_log) begin
                        n_ltot = CNT_W'(r_n);
                    end else begin
                        n_mtot = CNT_W'(r_n);
                    end
                end
            end
            S_RS_MOVE: begin
                // drop oldest records: reader lands cap slots behind the writer
                alu_op = ALU_SUB;
                alu_a  = UW'(r_wp);
                alu_b  = UW'(cap_eff);
                if (r_tgt_log) begin
                    n_lrd  = alu_wrap[PW-1:0];
                    n_ltot = cap_eff;
                end else begin
                    n_mrd  = alu_wrap[PW-1:0];
                    n_mtot = cap_eff;
                end
            end
            S_MAIN_CHK: begin
                alu_op = ALU_ADD;
                alu_a  = UW'(r_mrd);
                alu_b  = UW'(1);
                if (r_mtot == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    // an invalid record is skipped all the same
                    n_rs      = r_mrd;
                    n_rv      = r_valid;
                    n_status  = r_valid ? ST_OK : ST_INVALID;
                    n_mrd     = alu_wrap[PW-1:0];
                    n_tgt_log = 1'b0;
                    n_ret     = S_LC_DIST;
                end
            end
            S_LOG_CHK: begin
                alu_op = ALU_ADD;
                alu_a  = UW'(r_lrd);
                alu_b  = UW'(1);
                if (r_ltot == '0) begin
                    n_log_on = 1'b0;
                    n_status = ST_EMPTY;
                end else begin
                    n_rs = r_lrd;
                    if (!r_valid) begin
                        // log head stays put and the log reader stops
                        n_log_on = 1'b0;
                        n_status = ST_INVALID;
                    end else begin
                        n_rv      = 1'b1;
                        n_lrd     = alu_wrap[PW-1:0];
                        n_tgt_log = 1'b1;
                        n_ret     = S_LC_DIST;
                    end
                end
            end
            S_LC_DIST: begin
                alu_op = ALU_SUB;
                alu_a  = UW'(r_wp);
                alu_b  = UW'(r_lrd);
                if (r_log_on) begin
                    n_n = alu_wrap[PW-1:0];
                end
            end
            S_LC_CMP: begin
                // log count reported capped, stored total left alone
                alu_op = ALU_SUB;
                alu_a  = UW'(cap_eff);
                alu_b  = UW'(r_n);
                n_lc   = alu_neg ? cap_eff : CNT_W'(r_n);
            end
            default: ;
        endcase
    end

    // control and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_tgt_log <= 1'b0;
            r_wp      <= '0;
            r_wsec    <= '0;
            r_woff    <= '0;
            r_mrd     <= '0;
            r_lrd     <= '0;
            r_mtot    <= '0;
            r_ltot    <= '0;
            r_log_on  <= 1'b0;
            r_cap     <= CAP_RESET;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_tgt_log <= n_tgt_log;
            r_wp      <= n_wp;
            r_wsec    <= n_wsec;
            r_woff    <= n_woff;
            r_mrd     <= n_mrd;
            r_lrd     <= n_lrd;
            r_mtot    <= n_mtot;
            r_ltot    <= n_ltot;
            r_log_on  <= n_log_on;
            r_done    <= (r_state == S_DONE);
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // scratch and result payload
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_valid  <= n_valid;
        r_status <= n_status;
        r_ev     <= n_ev;
        r_es     <= n_es;
        r_wv     <= n_wv;
        r_ws     <= n_ws;
        r_rv     <= n_rv;
        r_rs     <= n_rs;
        r_lc     <= n_lc;
        if (r_state == S_DONE) begin
            r_result.status         <= r_status;
            r_result.erase_valid    <= r_ev;
            r_result.erase_sector   <= SECTOR_W'(r_es);
            r_result.write_valid    <= r_wv;
            r_result.write_slot     <= SLOT_W'(r_ws);
            r_result.read_valid     <= r_rv;
            r_result.read_slot      <= SLOT_W'(r_rs);
            r_result.stored_count   <= r_mtot;
            r_result.log_count      <= r_lc;
            r_result.log_active     <= r_log_on;
            r_result.next_main_slot <= SLOT_W'(r_mrd);
            r_result.next_log_slot  <= SLOT_W'(r_lrd);
        end
    end

    // result strobe and result word
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: sv/cflp_checker.sv
// port-level checks for the flash log pointer manager, bound to the top level
`timescale 1ns / 1ps

module cflp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input cflp_pkg::t_result o_result
);
    import cflp_pkg::*;

    // busy goes high after a word is accepted
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // the strobe comes only once the block is ready again
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_log_count_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.log_active) |-> (o_result.log_count == '0))
        else $error("log count reported with the log reader off");

    a_log_off_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_LOG_OFF)) |-> !o_result.log_active)
        else $error("inactive-reader status with the log reader on");

endmodule

bind circular_flash_log_pointer_manager_top cflp_checker u_cflp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
